// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin thread slot scheduler: slot
// states, request modes, sequencer states and the default slot count.
// ----------------------------------------------------------------------------
package rrts_pkg;

	// default number of thread slots
	localparam int unsigned SLOTS_DEFAULT = 8;

	// request mode codes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_KILL  = 2'd1;
	localparam logic [1:0] MODE_SCHED = 2'd2;

	// state of one thread slot
	typedef enum logic [1:0] {
		SLOT_FREE    = 2'd0,
		SLOT_WAITING = 2'd1,
		SLOT_RUNNING = 2'd2
	} slot_state_t;

	// sequencer states
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_RETIRE,
		SEQ_DONE
	} seq_state_t;

endpackage

// ===== hdl/rrts_slot_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_slot_ram
// Slot state table: one write port, one read port with registered data.
// A valid bit per entry makes every entry read as free after reset.
// ----------------------------------------------------------------------------
module rrts_slot_ram #(
	parameter int unsigned SLOTS = rrts_pkg::SLOTS_DEFAULT,
	parameter int unsigned AW    = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output rrts_pkg::slot_state_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  rrts_pkg::slot_state_t wr_data
);
	import rrts_pkg::*;

	slot_state_t              mem [SLOTS];
	logic        [SLOTS-1:0]  valid_q;
	slot_state_t              rd_raw_s1;
	logic                     rd_vld_s1;

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_s1 <= mem[rd_addr];
		end
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// never-written entries read as free
	assign rd_data = rd_vld_s1 ? rd_raw_s1 : SLOT_FREE;

endmodule

// ===== hdl/round_robin_thread_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler
// Thread slot table with claim, free and round-robin schedule requests.
// Input channel (in_valid/in_ready) carries mode and slot; output channel
// (out_valid/out_ready) returns status, slot_out, current_slot_out and
// current_valid, one result per request, in order.
// A kill or an unknown mode goes straight from idle to the final state.
// A start or schedule walks the slot table one entry per cycle through the
// single read port of the table memory, and it passes through a retire step
// when a running slot is sent back to waiting.
// One request is in progress at a time; the next is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// A stalled receiver holds the result register and, once a second result is
// ready, the sequencer waits in its final state and stops taking requests.
// Reset empties the output, marks every slot free and clears the current
// slot; no clearing pass is needed, the block takes requests right away.
// ----------------------------------------------------------------------------
module round_robin_thread_slot_scheduler #(
	parameter int unsigned SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [2:0] slot,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [2:0] slot_out,
	output logic [2:0] current_slot_out,
	output logic       current_valid
);
	import rrts_pkg::*;

	localparam int unsigned SW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);

	seq_state_t    state_q, state_d;
	logic [1:0]    mode_q;
	logic [SW-1:0] rd_addr_q;
	logic [CW-1:0] left_q;
	logic [SW-1:0] addr_s1;
	logic          chk_s1;
	logic          res_status_q;
	logic [SW-1:0] res_slot_q;
	logic [SW-1:0] cur_q;
	logic [SW-1:0] old_cur_q;
	logic          has_cur_q;
	logic          cur_run_q;
	logic          out_valid_q;
	logic          status_q;
	logic [2:0]    slot_out_q;
	logic [2:0]    cur_out_q;
	logic          cur_valid_q;

	logic          in_fire;
	logic          out_free;
	logic [SW+2:0] slot_ext;
	logic [SW-1:0] kill_addr;
	logic          kill_ok;
	logic [SW-1:0] next_rd_addr;
	logic [SW-1:0] sched_first;
	logic          rd_en;
	slot_state_t   rd_data;
	slot_state_t   target;
	logic          found;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	slot_state_t   wr_data;
	logic [SW+2:0] res_slot_ext;
	logic [SW+2:0] cur_ext;

	// handshake and request decode
	assign in_ready  = (state_q == SEQ_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign slot_ext  = {{SW{1'b0}}, slot};
	assign kill_addr = slot_ext[SW-1:0];
	assign kill_ok   = (slot_ext < (SW + 3)'(SLOTS));

	// round-robin address stepping
	assign next_rd_addr = (rd_addr_q == SW'(SLOTS - 1)) ? '0 : rd_addr_q + 1'b1;
	assign sched_first  = (cur_q == SW'(SLOTS - 1)) ? '0 : cur_q + 1'b1;

	// scan match against the slot state sought
	assign target = (mode_q == MODE_START) ? SLOT_FREE : SLOT_WAITING;
	assign found  = (state_q == SEQ_SCAN) && chk_s1 && (rd_data == target);
	assign rd_en  = (state_q == SEQ_SCAN) && (left_q != '0) && !found;

	// slot table
	rrts_slot_ram #(
		.SLOTS (SLOTS),
		.AW    (SW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_fire) begin
					if (mode == MODE_START || mode == MODE_SCHED) begin
						state_d = SEQ_SCAN;
					end else begin
						state_d = SEQ_DONE;
					end
				end
			end
			SEQ_SCAN: begin
				if (found) begin
					if (mode_q == MODE_SCHED && has_cur_q && cur_run_q) begin
						state_d = SEQ_RETIRE;
					end else begin
						state_d = SEQ_DONE;
					end
				end else if (!chk_s1 && left_q == '0) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_RETIRE: begin
				state_d = SEQ_DONE;
			end
			SEQ_DONE: begin
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// table writes per state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = SLOT_FREE;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_fire && mode == MODE_KILL && kill_ok) begin
					wr_en   = 1'b1;
					wr_addr = kill_addr;
					wr_data = SLOT_FREE;
				end
			end
			SEQ_SCAN: begin
				if (found) begin
					wr_en   = 1'b1;
					wr_addr = addr_s1;
					wr_data = (mode_q == MODE_START) ? SLOT_WAITING : SLOT_RUNNING;
				end
			end
			SEQ_RETIRE: begin
				wr_en   = 1'b1;
				wr_addr = old_cur_q;
				wr_data = SLOT_WAITING;
			end
			SEQ_DONE: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			chk_s1    <= 1'b0;
			cur_q     <= '0;
			has_cur_q <= 1'b0;
			cur_run_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= rd_en;
			if (in_fire && mode == MODE_KILL && kill_ok && has_cur_q && kill_addr == cur_q) begin
				cur_run_q <= 1'b0;
			end
			if (found && mode_q == MODE_SCHED) begin
				cur_q     <= addr_s1;
				has_cur_q <= 1'b1;
				cur_run_q <= 1'b1;
			end
		end
	end

	// request and scan datapath
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1   <= rd_addr_q;
			rd_addr_q <= next_rd_addr;
			left_q    <= left_q - 1'b1;
		end
		if (in_fire) begin
			mode_q       <= mode;
			res_slot_q   <= '0;
			res_status_q <= (mode == MODE_KILL) ? !kill_ok : 1'b1;
			if (mode == MODE_SCHED && has_cur_q) begin
				rd_addr_q <= sched_first;
				left_q    <= CW'(SLOTS - 1);
			end else begin
				rd_addr_q <= '0;
				left_q    <= CW'(SLOTS);
			end
		end
		if (found) begin
			res_status_q <= 1'b0;
			res_slot_q   <= addr_s1;
			old_cur_q    <= cur_q;
		end
	end

	// result register
	assign res_slot_ext = {3'b000, res_slot_q};
	assign cur_ext      = {3'b000, cur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == SEQ_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_DONE && out_free) begin
			status_q    <= res_status_q;
			slot_out_q  <= res_slot_ext[2:0];
			cur_out_q   <= cur_ext[2:0];
			cur_valid_q <= has_cur_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign slot_out         = slot_out_q;
	assign current_slot_out = cur_out_q;
	assign current_valid    = cur_valid_q;

endmodule
